@@ hw/rtl/wprs_pkg.sv @@
// wprs_pkg: shared types and constants for the window peak RGB search block
// no dependencies; imported by wprs_peak, wprs_seq and the top level

package wprs_pkg;

	// default geometry, handed down from the top-level parameters
	localparam int DEF_MAX_SIDE      = 128;
	localparam int DEF_WINDOW_RADIUS = 12;

	// field widths
	localparam int COORD_W = 8;
	localparam int CHAN_W  = 16;
	localparam int TEXEL_W = 3 * CHAN_W;
	localparam int CFG_W   = 8;
	// extent after clamping can reach 256
	localparam int EXT_W   = CFG_W + 1;
	// signed scan coordinate, covers -radius .. 255 + radius
	localparam int SCAN_W  = COORD_W + 2;

	// largest channel pattern that may win, positive infinity as half float
	localparam logic [CHAN_W-1:0] HALF_POS_INF = 16'h7C00;

	// reset values of the size registers
	localparam logic [CFG_W-1:0] TEX_SIZE_RESET = 8'd128;

	// command codes on tuser
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// configuration register indexes
	localparam logic REG_TEX_WIDTH  = 1'b0;
	localparam logic REG_TEX_HEIGHT = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} seq_state_t;

	// control from sequencer to the shared compare unit
	typedef struct packed {
		logic clear;
		logic take;
	} pk_ctrl_t;

endpackage

@@ hw/rtl/wprs_ram.sv @@
// wprs_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module wprs_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/wprs_peak.sv @@
// wprs_peak: shared compare unit holding the running per-channel maxima
// depends on wprs_pkg

module wprs_peak (
	input  logic                                clk,
	input  wprs_pkg::pk_ctrl_t                  ctrl,
	input  logic [wprs_pkg::TEXEL_W-1:0]        texel,
	output logic [wprs_pkg::TEXEL_W-1:0]        peak
);

	import wprs_pkg::*;

	logic [CHAN_W-1:0] peak_q [3];
	logic [CHAN_W-1:0] cand   [3];
	logic              wins   [3];

	// one compare per channel: only non-negative, non-NaN values may win
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			cand[c] = texel[c*CHAN_W +: CHAN_W];
			wins[c] = (cand[c] <= HALF_POS_INF) && (cand[c] > peak_q[c]);
		end
	end

	// running maxima, cleared at the start of each query
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (ctrl.clear) begin
				peak_q[c] <= '0;
			end else if (ctrl.take && wins[c]) begin
				peak_q[c] <= cand[c];
			end
		end
	end

	assign peak = {peak_q[2], peak_q[1], peak_q[0]};

endmodule

@@ hw/rtl/wprs_seq.sv @@
// wprs_seq: window scan sequencer, walks the window one texel per cycle
// depends on wprs_pkg

module wprs_seq #(
	parameter int MAX_SIDE      = wprs_pkg::DEF_MAX_SIDE,
	parameter int WINDOW_RADIUS = wprs_pkg::DEF_WINDOW_RADIUS
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// request side
	input  logic                                      req_valid,
	input  logic                                      req_cmd,
	input  logic [wprs_pkg::COORD_W-1:0]              req_u,
	input  logic [wprs_pkg::COORD_W-1:0]              req_v,
	output logic                                      ready,
	// size registers
	input  logic [wprs_pkg::CFG_W-1:0]                tex_width,
	input  logic [wprs_pkg::CFG_W-1:0]                tex_height,
	// store read port
	output logic                                      rd_en,
	output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]      rd_addr,
	// compare unit control
	output wprs_pkg::pk_ctrl_t                        pk_ctrl,
	// result register
	input  logic                                      out_busy,
	output logic                                      load_out
);

	import wprs_pkg::*;

	localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
	localparam logic [EXT_W-1:0] SIDE_EXT = EXT_W'(MAX_SIDE);
	localparam logic signed [SCAN_W-1:0] RAD = SCAN_W'(WINDOW_RADIUS);

	seq_state_t state_q, state_nxt;

	logic signed [SCAN_W-1:0] x_q, y_q, x0_q, xend_q, yend_q;
	logic [EXT_W-1:0]         w_q, h_q;
	logic                     take_s1;

	logic                     start;
	logic                     row_end;
	logic                     last_pos;
	logic                     pos_ok;
	logic signed [SCAN_W-1:0] u_s, v_s;
	logic [EXT_W-1:0]         w_ext, h_ext;

	assign u_s = signed'(SCAN_W'(req_u));
	assign v_s = signed'(SCAN_W'(req_v));

	// clamp the configured extents to the store side
	assign w_ext = ({1'b0, tex_width} > SIDE_EXT) ? SIDE_EXT : {1'b0, tex_width};
	assign h_ext = ({1'b0, tex_height} > SIDE_EXT) ? SIDE_EXT : {1'b0, tex_height};

	assign start    = (state_q == ST_IDLE) && req_valid && (req_cmd == CMD_QUERY);
	assign row_end  = (x_q == xend_q);
	assign last_pos = row_end && (y_q == yend_q);

	// window position inside the used area
	assign pos_ok = !x_q[SCAN_W-1] && !y_q[SCAN_W-1]
		&& (x_q[EXT_W-1:0] < w_q) && (y_q[EXT_W-1:0] < h_q);

	assign rd_addr = AW'(AW'(y_q[EXT_W-1:0]) * AW'(MAX_SIDE)) + AW'(x_q[EXT_W-1:0]);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_pos) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!out_busy) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ready         = (state_q == ST_IDLE);
		rd_en         = (state_q == ST_SCAN) && pos_ok;
		load_out      = (state_q == ST_DONE) && !out_busy;
		pk_ctrl.clear = start;
		pk_ctrl.take  = take_s1;
	end

	// state and read-valid pipeline bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			take_s1 <= 1'b0;
		end else begin
			state_q <= state_nxt;
			take_s1 <= rd_en;
		end
	end

	// window counters
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= u_s - RAD;
			x0_q   <= u_s - RAD;
			xend_q <= u_s + RAD;
			y_q    <= v_s - RAD;
			yend_q <= v_s + RAD;
			w_q    <= w_ext;
			h_q    <= h_ext;
		end else if (state_q == ST_SCAN) begin
			if (row_end) begin
				x_q <= x0_q;
				y_q <= y_q + SCAN_W'(1);
			end else begin
				x_q <= x_q + SCAN_W'(1);
			end
		end
	end

	// reads are issued only while scanning
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (state_q == ST_SCAN))
		else $error("store read outside scan");

	// a query request starts a scan on the next cycle
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == ST_SCAN))
		else $error("query did not start scan");

	// the last read is folded in before the result is taken
	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_DONE) && !pk_ctrl.take)
		else $error("drain sequence broken");

	// no compare update may coincide with a clear
	a_clear_take: assert property (@(posedge clk) disable iff (!arst_n)
		pk_ctrl.clear |-> !pk_ctrl.take)
		else $error("clear during accumulate");

endmodule

@@ hw/rtl/window_peak_rgb_search.sv @@
// window_peak_rgb_search: top level, texel store plus windowed max search
// depends on wprs_pkg, wprs_ram, wprs_seq, wprs_peak
//
// Usage:
//   s_* channel carries requests. s_tuser is the command: write texel or
//   query. A write stores (red, green, blue) at (u, v); writes at or
//   beyond the store side are dropped. A query scans the (2R+1)x(2R+1)
//   window around (u, v), one texel position per cycle through the single
//   store read port, skipping positions outside the configured width and
//   height, and returns one result on m_*. s_tready is low while a query
//   runs. The scan length, set by the one read port of the store, fixes
//   the rate. The result sits in an output register, so a new request is
//   taken while it waits; a following query holds its result until
//   m_tready frees the register. Size registers are written through
//   cfg_we/cfg_index/cfg_data; the user must write them only while idle,
//   which the block does not enforce. Reset sets both sizes to 128 and
//   empties the output; the store is not cleared and must be written
//   before it is queried.

module window_peak_rgb_search #(
	parameter int MAX_SIDE      = wprs_pkg::DEF_MAX_SIDE,
	parameter int WINDOW_RADIUS = wprs_pkg::DEF_WINDOW_RADIUS
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // u_coord[7:0], v_coord[15:8], red_in[31:16],
	                              // green_in[47:32], blue_in[63:48]
	input  logic        s_tuser,  // cmd
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // peak_red[15:0], peak_green[31:16], peak_blue[47:32]
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	import wprs_pkg::*;

	localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
	localparam logic [EXT_W-1:0] SIDE_EXT = EXT_W'(MAX_SIDE);

	logic [CFG_W-1:0]   tex_width_q, tex_height_q;
	logic [COORD_W-1:0] u_in, v_in;
	logic [TEXEL_W-1:0] texel_in, rd_data, peak;
	logic               wr_en, rd_en, load_out, out_busy;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic               out_valid_q;
	logic [TEXEL_W-1:0] out_data_q;
	pk_ctrl_t           pk_ctrl;

	assign u_in     = s_tdata[7:0];
	assign v_in     = s_tdata[15:8];
	assign texel_in = s_tdata[63:16];

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= TEX_SIZE_RESET;
			tex_height_q <= TEX_SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEX_WIDTH:  tex_width_q  <= cfg_data;
				REG_TEX_HEIGHT: tex_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// texel write, dropped outside the store
	assign wr_en = s_tvalid && s_tready && (s_tuser == CMD_WRITE)
		&& ({1'b0, u_in} < SIDE_EXT) && ({1'b0, v_in} < SIDE_EXT);
	assign wr_addr = AW'(AW'(v_in) * AW'(MAX_SIDE)) + AW'(u_in);

	wprs_ram #(
		.WIDTH (TEXEL_W),
		.DEPTH (MAX_SIDE * MAX_SIDE)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (texel_in),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	wprs_seq #(
		.MAX_SIDE      (MAX_SIDE),
		.WINDOW_RADIUS (WINDOW_RADIUS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (s_tvalid),
		.req_cmd    (s_tuser),
		.req_u      (u_in),
		.req_v      (v_in),
		.ready      (s_tready),
		.tex_width  (tex_width_q),
		.tex_height (tex_height_q),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.pk_ctrl    (pk_ctrl),
		.out_busy   (out_busy),
		.load_out   (load_out)
	);

	wprs_peak u_peak (
		.clk   (clk),
		.ctrl  (pk_ctrl),
		.texel (rd_data),
		.peak  (peak)
	);

	// output register
	assign out_busy = out_valid_q && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= peak;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
